// File: src/charlieplex_matrix_scanner_macros.svh
// ----------------------------------------------------------------------------
// Charlieplex matrix scanner assertion macros
// Shared concurrent assertion forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef CHARLIEPLEX_MATRIX_SCANNER_MACROS_SVH
`define CHARLIEPLEX_MATRIX_SCANNER_MACROS_SVH

// Checked on every edge, reset included
`define CPMS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while out of reset
`define CPMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// File: src/cpms_pkg.sv
// ----------------------------------------------------------------------------
// cpms_pkg
// Shared types and constants of the charlieplex matrix scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package cpms_pkg;

  // Default geometry
  localparam int LINES_DEF   = 10;
  localparam int MAX_LIT_DEF = 20;

  // Fixed field widths
  localparam int REQ_W     = 2;
  localparam int COORD_W   = 4;
  localparam int OFS_W     = 3;
  localparam int COLB_W    = 5;
  localparam int OUT_W     = 11;
  localparam int CNT_OUT_W = 5;
  localparam int ROW_WIN   = 5;   // rows moved by a scroll
  localparam int WIDE_W    = 16;  // largest line count plus the diagonal word

  // Request codes
  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SWAP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SCROLL = 2'd2;
  localparam logic [REQ_W-1:0] REQ_SCAN   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic write_pix;
    logic swap_begin;
    logic scroll_begin;
    logic walk_step;
    logic emit_zero;
    logic mod_begin;
    logic mod_sub;
    logic mod_done;
    logic emit;
  } cpms_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic walk_last;
    logic mod_ge;
    logic lit_zero;
  } cpms_stat_t;

endpackage

`default_nettype wire

// File: src/cpms_ctrl.sv
// ----------------------------------------------------------------------------
// cpms_ctrl
// Sequencer: decodes requests and steps the datapath through list rebuilds
// and scan ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module cpms_ctrl
  import cpms_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [REQ_W-1:0] req_type,
  input  cpms_stat_t       stat,
  output logic             busy,
  output cpms_cmd_t        cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;
  localparam logic [1:0] ST_READ = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (req_type)
            REQ_WRITE: begin
              cmd.write_pix = 1'b1;
            end
            REQ_SWAP: begin
              cmd.swap_begin = 1'b1;
              state_nxt      = ST_WALK;
            end
            REQ_SCROLL: begin
              cmd.scroll_begin = 1'b1;
              state_nxt        = ST_WALK;
            end
            REQ_SCAN: begin
              if (stat.lit_zero) begin
                cmd.emit_zero = 1'b1;
              end else begin
                cmd.mod_begin = 1'b1;
                state_nxt     = ST_MOD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) state_nxt = ST_IDLE;
      end
      ST_MOD: begin
        if (stat.mod_ge) begin
          cmd.mod_sub = 1'b1;
        end else begin
          cmd.mod_done = 1'b1;
          state_nxt    = ST_READ;
        end
      end
      ST_READ: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

// File: src/cpms_datapath.sv
// ----------------------------------------------------------------------------
// cpms_datapath
// Frame buffers, lit list memory, walk and scan counters, output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cpms_datapath
  import cpms_pkg::*;
#(
  parameter int LINES   = LINES_DEF,
  parameter int MAX_LIT = MAX_LIT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cpms_cmd_t            cmd,
  output cpms_stat_t           stat,
  input  logic [COORD_W-1:0]   in_pixel_row,
  input  logic [COORD_W-1:0]   in_pixel_col,
  input  logic                 in_pixel_value,
  input  logic [OFS_W-1:0]     in_row_offset,
  input  logic [COLB_W-1:0]    in_column_bits,
  output logic                 out_valid,
  output logic [OUT_W-1:0]     out_line_enable,
  output logic [OUT_W-1:0]     out_line_level,
  output logic [CNT_OUT_W-1:0] out_lit_count
);

  localparam int NPIX  = LINES * LINES;
  localparam int PIX_W = $clog2(NPIX);
  localparam int CNT_W = $clog2(MAX_LIT + 1);
  localparam int IDX_W = (MAX_LIT > 1) ? $clog2(MAX_LIT) : 1;
  localparam int ENT_W = 2 * COORD_W;
  localparam int EXT_W = CNT_W + CNT_OUT_W;
  localparam logic [WIDE_W-1:0] WMASK = WIDE_W'((32'd1 << (LINES + 1)) - 32'd1);

  // Frames are held as a pixel matrix, bit r*LINES+c for pixel (r,c)
  logic [NPIX-1:0]    frame0_r;
  logic [NPIX-1:0]    frame1_r;
  logic               front_r;
  logic [NPIX-1:0]    front_vec;
  logic [NPIX-1:0]    scroll_vec;

  logic [COORD_W-1:0] row_r;
  logic [COORD_W-1:0] col_r;
  logic [PIX_W-1:0]   pix_r;
  logic [CNT_W-1:0]   lit_k_r;
  logic [CNT_W-1:0]   lit_k_nxt;
  logic [CNT_W-1:0]   lit_total_r;
  logic [CNT_W-1:0]   ptr_r;
  logic [CNT_W-1:0]   mod_r;
  logic               walk_bit;
  logic               take;

  logic [ENT_W-1:0]   lit_mem [MAX_LIT];
  logic [ENT_W-1:0]   rd_r;

  logic               wr_ok;
  logic [PIX_W-1:0]   wr_idx;

  logic [COORD_W-1:0] er;
  logic [COORD_W-1:0] ec;
  logic [COORD_W-1:0] word;
  logic [WIDE_W-1:0]  colbit;
  logic [WIDE_W-1:0]  en_wide;
  logic [WIDE_W-1:0]  lv_wide;
  logic [EXT_W-1:0]   cnt_ext;

  logic               out_valid_r;
  logic [OUT_W-1:0]   out_enable_r;
  logic [OUT_W-1:0]   out_level_r;
  logic [CNT_OUT_W-1:0] out_count_r;

  assign front_vec = front_r ? frame1_r : frame0_r;

  // Pixel write decode
  assign wr_ok  = (in_pixel_row < COORD_W'(LINES)) && (in_pixel_col < COORD_W'(LINES));
  assign wr_idx = PIX_W'(int'(in_pixel_row) * LINES + int'(in_pixel_col));

  // Scroll: shift the window rows one column left, new column on the right
  always_comb begin
    logic [COORD_W-1:0] dr;
    logic               in_win;
    scroll_vec = front_vec;
    for (int r = 0; r < LINES; r++) begin
      dr     = COORD_W'(r) - COORD_W'(in_row_offset);
      in_win = (COORD_W'(r) >= COORD_W'(in_row_offset)) && (dr < COORD_W'(ROW_WIN));
      for (int c = 0; c < LINES; c++) begin
        if (in_win) begin
          if (c < LINES - 1) begin
            scroll_vec[r*LINES+c] = front_vec[r*LINES+c+1];
          end else begin
            scroll_vec[r*LINES+c] = in_column_bits[dr[OFS_W-1:0]];
          end
        end
      end
    end
  end

  // Frame buffers and front select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame0_r <= '0;
      frame1_r <= '0;
      front_r  <= 1'b0;
    end else begin
      if (cmd.write_pix && wr_ok) begin
        if (front_r) frame0_r[wr_idx] <= in_pixel_value;
        else         frame1_r[wr_idx] <= in_pixel_value;
      end
      if (cmd.scroll_begin) begin
        if (front_r) frame0_r <= scroll_vec;
        else         frame1_r <= scroll_vec;
      end
      if (cmd.swap_begin || cmd.scroll_begin) front_r <= ~front_r;
    end
  end

  // Row-major walk over the new front frame
  assign walk_bit  = front_vec[pix_r];
  assign take      = walk_bit && (lit_k_r < CNT_W'(MAX_LIT));
  assign lit_k_nxt = lit_k_r + CNT_W'(take);

  assign stat.walk_last = (row_r == COORD_W'(LINES - 1)) && (col_r == COORD_W'(LINES - 1));
  assign stat.mod_ge    = (mod_r >= lit_total_r);
  assign stat.lit_zero  = (lit_total_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      pix_r       <= '0;
      lit_k_r     <= '0;
      lit_total_r <= '0;
      ptr_r       <= '0;
      mod_r       <= '0;
    end else begin
      if (cmd.swap_begin || cmd.scroll_begin) begin
        row_r   <= '0;
        col_r   <= '0;
        pix_r   <= '0;
        lit_k_r <= '0;
      end
      if (cmd.walk_step) begin
        if (col_r == COORD_W'(LINES - 1)) begin
          col_r <= '0;
          row_r <= row_r + COORD_W'(1);
        end else begin
          col_r <= col_r + COORD_W'(1);
        end
        pix_r   <= pix_r + PIX_W'(1);
        lit_k_r <= lit_k_nxt;
        if (stat.walk_last) lit_total_r <= lit_k_nxt;
      end
      // Pointer step: (ptr + 1) mod total by repeated subtraction
      if (cmd.mod_begin) mod_r <= ptr_r + CNT_W'(1);
      if (cmd.mod_sub)   mod_r <= mod_r - lit_total_r;
      if (cmd.mod_done)  ptr_r <= mod_r;
    end
  end

  // Lit list memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.walk_step && take) lit_mem[lit_k_r[IDX_W-1:0]] <= {row_r, col_r};
    if (cmd.mod_done)          rd_r <= lit_mem[mod_r[IDX_W-1:0]];
  end

  // Line drive pattern for the selected pixel
  assign er      = rd_r[ENT_W-1:COORD_W];
  assign ec      = rd_r[COORD_W-1:0];
  assign word    = (er == ec) ? COORD_W'(LINES) : ec;
  assign colbit  = WIDE_W'(1) << word;
  assign en_wide = colbit | (WIDE_W'(1) << er);
  assign lv_wide = ~colbit & WMASK;
  assign cnt_ext = EXT_W'(lit_total_r);

  // Result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_zero || cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_zero) begin
      out_enable_r <= '0;
      out_level_r  <= '0;
      out_count_r  <= '0;
    end else if (cmd.emit) begin
      out_enable_r <= en_wide[OUT_W-1:0];
      out_level_r  <= lv_wide[OUT_W-1:0];
      out_count_r  <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_line_enable = out_enable_r;
  assign out_line_level  = out_level_r;
  assign out_lit_count   = out_count_r;

endmodule

`default_nettype wire

// File: src/charlieplex_matrix_scanner.sv
// ----------------------------------------------------------------------------
// charlieplex_matrix_scanner
// Double-buffered charlieplexed LED matrix driver with a lit-pixel scan list.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start when busy is low; in_req_type selects pixel write,
//   commit swap, scroll column in, or scan tick. Only a scan tick returns an
//   item, shown for one cycle on out_* with out_valid high.
//   Pixel write: busy stays low.
//   Commit or scroll: busy while the lit list is rebuilt
//     by walking the new front frame one pixel per cycle.
//   Scan tick, empty list: item appears the cycle after the request.
//   Scan tick otherwise: busy while the pointer wraps (an iterative subtract,
//     one per cycle), then through the registered lit list memory read and
//     the result register, from which the item is shown.
//   The receiver cannot stall: every item is taken in the cycle it is shown.
//   Reset (rst_n low, synchronous) clears both frames, the front select, the
//   lit count and the scan pointer; the lit list itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module charlieplex_matrix_scanner
  import cpms_pkg::*;
#(
  parameter int LINES   = LINES_DEF,
  parameter int MAX_LIT = MAX_LIT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [COORD_W-1:0]   in_pixel_row,
  input  logic [COORD_W-1:0]   in_pixel_col,
  input  logic                 in_pixel_value,
  input  logic [OFS_W-1:0]     in_row_offset,
  input  logic [COLB_W-1:0]    in_column_bits,
  output logic                 out_valid,
  output logic [OUT_W-1:0]     out_line_enable,
  output logic [OUT_W-1:0]     out_line_level,
  output logic [CNT_OUT_W-1:0] out_lit_count
);

  cpms_cmd_t  cmd;
  cpms_stat_t stat;

  // Sequencer
  cpms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .stat     (stat),
    .busy     (busy),
    .cmd      (cmd)
  );

  // Frames, lit list and result registers
  cpms_datapath #(
    .LINES   (LINES),
    .MAX_LIT (MAX_LIT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_pixel_row    (in_pixel_row),
    .in_pixel_col    (in_pixel_col),
    .in_pixel_value  (in_pixel_value),
    .in_row_offset   (in_row_offset),
    .in_column_bits  (in_column_bits),
    .out_valid       (out_valid),
    .out_line_enable (out_line_enable),
    .out_line_level  (out_line_level),
    .out_lit_count   (out_lit_count)
  );

endmodule

`default_nettype wire

// File: src/cpms_checker.sv
// ----------------------------------------------------------------------------
// cpms_checker
// Port-level checks of the charlieplex matrix scanner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "charlieplex_matrix_scanner_macros.svh"

module cpms_checker
  import cpms_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [REQ_W-1:0] in_req_type,
  input logic             out_valid,
  input logic [OUT_W-1:0] out_line_enable,
  input logic [OUT_W-1:0] out_line_level
);

  // Reset leaves the block idle with no item pending
  `CPMS_ASSERT_RST(a_reset_idle, !rst_n |=> (!busy && !out_valid), "not idle after reset")

  // A pixel write finishes at once and returns no item
  `CPMS_ASSERT(a_write_quiet, (start && !busy && in_req_type == REQ_WRITE) |=> (!busy && !out_valid), "pixel write took time or gave an item")

  // A commit always spends time rebuilding the lit list
  `CPMS_ASSERT(a_swap_busy, (start && !busy && in_req_type == REQ_SWAP) |=> busy, "commit did not go busy")

  // At most one driven line sinks current
  `CPMS_ASSERT(a_one_sink, out_valid |-> $onehot0(out_line_enable & ~out_line_level), "more than one sinking line")

endmodule

bind charlieplex_matrix_scanner cpms_checker u_cpms_checker (.*);

`default_nettype wire

// File: test/charlieplex_matrix_scanner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charlieplex_matrix_scanner_tb
// Drives pixel writes, commits, scrolls and scan ticks through the command
// port with random gaps. A tracker keeps its own copy of both frames and the
// lit list, predicts the line drive of every scan tick, and compares it field
// by field with what the block shows on out_*.
// ----------------------------------------------------------------------------

// Line drive expected from one scan tick
typedef struct packed {
  logic [cpms_pkg::OUT_W-1:0]     enable;
  logic [cpms_pkg::OUT_W-1:0]     level;
  logic [cpms_pkg::CNT_OUT_W-1:0] count;
} scan_drive_t;

// Frame and lit-list tracker plus queue of pending scan drives
class matrix_scan_tracker;
  localparam int LINES   = cpms_pkg::LINES_DEF;
  localparam int MAX_LIT = cpms_pkg::MAX_LIT_DEF;

  bit [LINES:0]   frame_words[2][LINES+1];
  bit             front;
  bit [3:0]       lit_row[MAX_LIT];
  bit [3:0]       lit_col[MAX_LIT];
  int unsigned    lit_n;
  int unsigned    scan_ptr;
  scan_drive_t    pending_drives[$];
  int             errors;

  function new();
    foreach (frame_words[f, w]) frame_words[f][w] = '0;
    front    = 1'b0;
    lit_n    = 0;
    scan_ptr = 0;
    errors   = 0;
  endfunction

  // Diagonal pixels live in the extra word
  function int word_of(int r, int c);
    return (r == c) ? LINES : c;
  endfunction

  function bit pixel(bit f, int r, int c);
    return frame_words[f][word_of(r, c)][r];
  endfunction

  function void set_pixel(bit f, int r, int c, bit v);
    frame_words[f][word_of(r, c)][r] = v;
  endfunction

  // Swap frames and collect lit pixels of the new front, row-major, capped
  function void swap_and_collect();
    front = ~front;
    lit_n = 0;
    for (int r = 0; r < LINES; r++)
      for (int c = 0; c < LINES; c++)
        if (lit_n < MAX_LIT && pixel(front, r, c)) begin
          lit_row[lit_n] = r[3:0];
          lit_col[lit_n] = c[3:0];
          lit_n++;
        end
  endfunction

  // Copy front to back, shift a five-row window left, insert a column, swap
  function void scroll_column(int h, bit [4:0] bits);
    bit back;
    back = ~front;
    for (int w = 0; w <= LINES; w++) frame_words[back][w] = frame_words[front][w];
    for (int c = 1; c < LINES; c++)
      for (int k = 0; k < cpms_pkg::ROW_WIN; k++)
        if (h + k < LINES) set_pixel(back, h + k, c - 1, pixel(front, h + k, c));
    for (int k = 0; k < cpms_pkg::ROW_WIN; k++)
      if (h + k < LINES) set_pixel(back, h + k, LINES - 1, bits[k]);
    swap_and_collect();
  endfunction

  // Update state for one accepted request; queue the drive of a scan tick
  function void accept_request(logic [1:0] req, logic [3:0] row, logic [3:0] col,
                               logic val, logic [2:0] off, logic [4:0] bits);
    scan_drive_t d;
    int r, c, idx;
    bit [31:0] colbit;
    case (req)
      cpms_pkg::REQ_WRITE: begin
        if (row < LINES && col < LINES) set_pixel(~front, row, col, val);
      end
      cpms_pkg::REQ_SWAP: begin
        swap_and_collect();
      end
      cpms_pkg::REQ_SCROLL: begin
        scroll_column(off, bits);
      end
      default: begin
        d = '0;
        if (lit_n != 0) begin
          scan_ptr = (scan_ptr + 1) % lit_n;
          idx      = (scan_ptr >= MAX_LIT) ? 0 : scan_ptr;
          r        = lit_row[idx];
          c        = lit_col[idx];
          colbit   = 32'd1 << word_of(r, c);
          d.level  = ~colbit[LINES:0];
          colbit   = colbit | (32'd1 << r);
          d.enable = colbit[cpms_pkg::OUT_W-1:0];
          d.count  = lit_n[cpms_pkg::CNT_OUT_W-1:0];
        end
        pending_drives.push_back(d);
      end
    endcase
  endfunction

  function void check_scan_drive(logic [10:0] en, logic [10:0] lvl, logic [4:0] cnt);
    scan_drive_t d;
    if (pending_drives.size() == 0) begin
      $display("%0t: unexpected scan item en=%h lvl=%h cnt=%0d", $time, en, lvl, cnt);
      errors++;
      return;
    end
    d = pending_drives.pop_front();
    if (en !== d.enable) begin
      $display("%0t: line_enable expected %h actual %h", $time, d.enable, en);
      errors++;
    end
    if (lvl !== d.level) begin
      $display("%0t: line_level expected %h actual %h", $time, d.level, lvl);
      errors++;
    end
    if (cnt !== d.count) begin
      $display("%0t: lit_count expected %0d actual %0d", $time, d.count, cnt);
      errors++;
    end
  endfunction
endclass

module charlieplex_matrix_scanner_tb;
  import cpms_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 128;
  localparam int RANDOM_ITEMS = 700;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [REQ_W-1:0]     in_req_type = REQ_WRITE;
  logic [COORD_W-1:0]   in_pixel_row = '0;
  logic [COORD_W-1:0]   in_pixel_col = '0;
  logic                 in_pixel_value = 1'b0;
  logic [OFS_W-1:0]     in_row_offset = '0;
  logic [COLB_W-1:0]    in_column_bits = '0;
  logic                 out_valid;
  logic [OUT_W-1:0]     out_line_enable;
  logic [OUT_W-1:0]     out_line_level;
  logic [CNT_OUT_W-1:0] out_lit_count;

  matrix_scan_tracker tracker = new();
  int                 cycle_count = 0;
  int                 items_sent = 0;

  charlieplex_matrix_scanner u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_pixel_row    (in_pixel_row),
    .in_pixel_col    (in_pixel_col),
    .in_pixel_value  (in_pixel_value),
    .in_row_offset   (in_row_offset),
    .in_column_bits  (in_column_bits),
    .out_valid       (out_valid),
    .out_line_enable (out_line_enable),
    .out_line_level  (out_line_level),
    .out_lit_count   (out_lit_count)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Accepted requests and shown items, sampled at the edge
  always @(posedge clk) begin
    if (rst_n && start && busy === 1'b0)
      tracker.accept_request(in_req_type, in_pixel_row, in_pixel_col,
                             in_pixel_value, in_row_offset, in_column_bits);
    if (rst_n && out_valid !== 1'b0)
      tracker.check_scan_drive(out_line_enable, out_line_level, out_lit_count);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("charlieplex_matrix_scanner verification failed");
      $finish;
    end
  end

  // Present one item and hold it until taken
  task automatic send_item(logic [1:0] req, logic [3:0] row, logic [3:0] col,
                           logic val, logic [2:0] off, logic [4:0] bits);
    start          <= 1'b1;
    in_req_type    <= req;
    in_pixel_row   <= row;
    in_pixel_col   <= col;
    in_pixel_value <= val;
    in_row_offset  <= off;
    in_column_bits <= bits;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (!(req == REQ_WRITE && (row >= LINES_DEF || col >= LINES_DEF)))
      items_sent++;
  endtask

  // Mostly short gaps, a few long ones; none while quiet is set
  task automatic idle_gap(bit quiet);
    int n, pick;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 60) n = 0;
    else if (pick < 94) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_gapped(logic [1:0] req, logic [3:0] row, logic [3:0] col,
                             logic val, logic [2:0] off, logic [4:0] bits, bit quiet);
    send_item(req, row, col, val, off, bits);
    idle_gap(quiet);
  endtask

  // Random item of a given type; coordinates mostly in range
  task automatic send_random(logic [1:0] req, int lit_pct, bit quiet);
    logic [3:0] row, col;
    row = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(0, 9))
                                       : 4'($urandom_range(10, 15));
    col = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(0, 9))
                                       : 4'($urandom_range(10, 15));
    send_gapped(req, row, col, $urandom_range(0, 99) < lit_pct,
                3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)), quiet);
  endtask

  initial begin
    int lit_pct, n;
    bit quiet;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, corners and diagonal, ignored writes
    send_gapped(REQ_SCAN,  4'd0,  4'd0,  1'b0, 3'd0, 5'd0,  1'b0);
    send_gapped(REQ_WRITE, 4'd0,  4'd0,  1'b1, 3'd0, 5'd0,  1'b0);
    send_gapped(REQ_WRITE, 4'd9,  4'd9,  1'b1, 3'd0, 5'd0,  1'b0);
    send_gapped(REQ_WRITE, 4'd9,  4'd0,  1'b1, 3'd0, 5'd0,  1'b0);
    send_gapped(REQ_WRITE, 4'd0,  4'd9,  1'b1, 3'd0, 5'd0,  1'b0);
    send_gapped(REQ_WRITE, 4'd3,  4'd5,  1'b1, 3'd0, 5'd0,  1'b0);
    send_gapped(REQ_WRITE, 4'd3,  4'd5,  1'b0, 3'd0, 5'd0,  1'b0);
    send_gapped(REQ_WRITE, 4'd15, 4'd15, 1'b1, 3'd7, 5'd31, 1'b0);
    send_gapped(REQ_WRITE, 4'd10, 4'd2,  1'b1, 3'd0, 5'd0,  1'b0);
    send_gapped(REQ_WRITE, 4'd2,  4'd10, 1'b1, 3'd0, 5'd0,  1'b0);
    // Commit, then walk the short list past its end
    send_gapped(REQ_SWAP,  4'd0,  4'd0,  1'b0, 3'd0, 5'd0,  1'b0);
    repeat (5) send_gapped(REQ_SCAN, 4'd0, 4'd0, 1'b0, 3'd0, 5'd0, 1'b0);
    // Scrolls: low window, high window, windows running off the bottom
    send_gapped(REQ_SCROLL, 4'd0, 4'd0, 1'b0, 3'd0, 5'd31, 1'b0);
    send_gapped(REQ_SCROLL, 4'd0, 4'd0, 1'b0, 3'd5, 5'd31, 1'b0);
    send_gapped(REQ_SCROLL, 4'd0, 4'd0, 1'b0, 3'd7, 5'd31, 1'b0);
    send_gapped(REQ_SCROLL, 4'd0, 4'd0, 1'b0, 3'd6, 5'd0,  1'b0);
    repeat (3) send_gapped(REQ_SCAN, 4'd0, 4'd0, 1'b0, 3'd0, 5'd0, 1'b0);
    send_gapped(REQ_SWAP, 4'd0, 4'd0, 1'b0, 3'd0, 5'd0, 1'b0);
    send_gapped(REQ_SCAN, 4'd0, 4'd0, 1'b0, 3'd0, 5'd0, 1'b0);

    // Random: write bursts, a commit or scroll, then scan runs; some noise
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 4))
        0: lit_pct = 10;
        1: lit_pct = 50;
        2: lit_pct = 90;
        3: lit_pct = 100;
        default: lit_pct = 30;
      endcase
      quiet = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 99) < 85) begin
        n = $urandom_range(0, 30);
        repeat (n) send_random(REQ_WRITE, lit_pct, quiet);
        send_random(($urandom_range(0, 2) == 0) ? REQ_SCROLL : REQ_SWAP, lit_pct, quiet);
        n = $urandom_range(1, 25);
        repeat (n) send_random(REQ_SCAN, lit_pct, quiet);
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) send_random(2'($urandom_range(0, 3)), lit_pct, quiet);
      end
    end

    // Drain
    start <= 1'b0;
    while (tracker.pending_drives.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("charlieplex_matrix_scanner verification clean");
    else
      $display("charlieplex_matrix_scanner verification failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/cpms_pkg.sv
src/cpms_ctrl.sv
src/cpms_datapath.sv
src/charlieplex_matrix_scanner.sv
src/cpms_checker.sv
test/charlieplex_matrix_scanner_tb.sv
